/* hdl/tx_input_output_record_parser_defines.svh */
// assertion macros used by the record parser checker
`ifndef TX_INPUT_OUTPUT_RECORD_PARSER_DEFINES_SVH
`define TX_INPUT_OUTPUT_RECORD_PARSER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TIOP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define TIOP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tiop_pkg.sv */
// types and constants of the transaction input/output record parser
`timescale 1ns / 1ps

package tiop_pkg;

    // result kinds
    localparam logic [1:0] RK_HASH   = 2'd0;
    localparam logic [1:0] RK_SCRIPT = 2'd1;
    localparam logic [1:0] RK_DONE   = 2'd2;
    localparam logic [1:0] RK_ERROR  = 2'd3;

    // parser phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_HASH   = 4'd1;
    localparam logic [3:0] PH_INDEX  = 4'd2;
    localparam logic [3:0] PH_LENPFX = 4'd3;
    localparam logic [3:0] PH_LENEXT = 4'd4;
    localparam logic [3:0] PH_SCRIPT = 4'd5;
    localparam logic [3:0] PH_SEQ    = 4'd6;
    localparam logic [3:0] PH_AMOUNT = 4'd7;
    localparam logic [3:0] PH_DONE   = 4'd8;

    // compact size prefixes and field constants
    localparam logic [7:0]  LEN_PFX16      = 8'hFD;
    localparam logic [7:0]  LEN_PFX32      = 8'hFE;
    localparam logic [7:0]  SEGWIT_MAX_OP  = 8'd16;
    localparam logic [31:0] COINBASE_INDEX = 32'hFFFF_FFFF;
    localparam logic [63:0] HASH_BYTES     = 64'd32;
    localparam logic [63:0] INDEX_BYTES    = 64'd4;
    localparam logic [63:0] AMOUNT_BYTES   = 64'd8;
    localparam logic [63:0] SEQ_BYTES      = 64'd4;

    // result queue
    localparam int QUEUE_AW          = 3;
    localparam int QUEUE_DEPTH       = 1 << QUEUE_AW;
    localparam int MAX_RESULTS       = 2;
    localparam int QUEUE_STALL_LEVEL = QUEUE_DEPTH - 2 * MAX_RESULTS;
    localparam logic [QUEUE_AW-1:0] QPTR_ONE = QUEUE_AW'(1);

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [7:0]         data_byte;
        logic [63:0]        byte_index;
        logic               record_kind;
        logic [31:0]        outpoint_index;
        logic [31:0]        sequence_number;
        logic signed [63:0] amount;
        logic [63:0]        script_length;
        logic [63:0]        consumed_length;
        logic               coinbase_flag;
        logic               segwit_flag;
        logic               last_of_run;
    } t_result;

endpackage

/* hdl/tx_input_output_record_parser.sv */
// top level of the transaction input/output record parser
`timescale 1ns / 1ps

// Parses one transaction input or output record per start byte, one byte per
// cycle. A byte is registered, then decoded against the parser state in the
// next cycle, and its one or two results go into an eight-entry result queue.
// Most bytes give at most one result; the byte that closes a script and the
// record, or that ends the payload inside the hash or a script, gives two,
// which leave the queue one after the other. The input stalls while the queue
// holds more than four results, so the sustained rate is one byte per cycle as
// long as the output takes one result per cycle and records are not dominated
// by two-result bytes.
module tx_input_output_record_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_in,
    input  logic               i_start_req,
    input  logic               i_action,
    input  logic               i_payload_end,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_result_kind,
    output logic [7:0]         o_data_byte,
    output logic [63:0]        o_byte_index,
    output logic               o_record_kind,
    output logic [31:0]        o_outpoint_index,
    output logic [31:0]        o_sequence_number,
    output logic signed [63:0] o_amount,
    output logic [63:0]        o_script_length,
    output logic [63:0]        o_consumed_length,
    output logic               o_coinbase_flag,
    output logic               o_segwit_flag,
    output logic               o_last_of_run
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_start;
    logic       r_in_action;
    logic       r_in_end;

    // parser state
    logic [3:0]  r_phase,     n_phase;
    logic        r_kind,      n_kind;
    logic [63:0] r_field_cnt, n_field_cnt;
    logic [3:0]  r_pfx_bytes, n_pfx_bytes;
    logic [63:0] r_length,    n_length;
    logic [31:0] r_index,     n_index;
    logic [31:0] r_sequence,  n_sequence;
    logic [63:0] r_amount,    n_amount;
    logic        r_hash_zero, n_hash_zero;
    logic        r_segwit,    n_segwit;
    logic [63:0] r_used,      n_used;

    // result queue
    tiop_pkg::t_result             r_q [tiop_pkg::QUEUE_DEPTH];
    logic [tiop_pkg::QUEUE_AW-1:0] r_head, r_tail;
    logic [tiop_pkg::QUEUE_AW:0]   r_count, n_count;

    tiop_pkg::t_result res_first, res_close, slot0, slot1, w_head;
    logic              has_first, has_close;
    logic [1:0]        push_cnt;
    logic              in_accept, out_pop;

    assign o_in_stall  = (r_count > (tiop_pkg::QUEUE_AW + 1)'(tiop_pkg::QUEUE_STALL_LEVEL));
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign out_pop     = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept;
        end
        if (in_accept) begin
            r_in_data   <= i_data_in;
            r_in_start  <= i_start_req;
            r_in_action <= i_action;
            r_in_end    <= i_payload_end;
        end
    end

    // byte decode
    always_comb begin
        logic active;
        logic done;
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_field_cnt = r_field_cnt;
        n_pfx_bytes = r_pfx_bytes;
        n_length    = r_length;
        n_index     = r_index;
        n_sequence  = r_sequence;
        n_amount    = r_amount;
        n_hash_zero = r_hash_zero;
        n_segwit    = r_segwit;
        n_used      = r_used;
        res_first   = '0;
        res_close   = '0;
        has_first   = 1'b0;
        has_close   = 1'b0;
        active      = 1'b0;
        done        = 1'b0;

        if (r_in_valid) begin
            if (r_in_start) begin
                n_field_cnt = '0;
                n_pfx_bytes = '0;
                n_length    = '0;
                n_index     = '0;
                n_sequence  = '0;
                n_amount    = '0;
                n_hash_zero = 1'b1;
                n_segwit    = 1'b0;
                n_used      = '0;
                n_kind      = r_in_action;
                n_phase     = r_in_action ? tiop_pkg::PH_AMOUNT : tiop_pkg::PH_HASH;
                active      = 1'b1;
            end else begin
                active = (r_phase >= tiop_pkg::PH_HASH) && (r_phase <= tiop_pkg::PH_AMOUNT);
            end
        end

        if (active) begin
            if (n_used != '1) begin
                n_used = n_used + 64'd1;
            end
            unique case (n_phase)
                tiop_pkg::PH_HASH: begin
                    has_first             = 1'b1;
                    res_first.result_kind = tiop_pkg::RK_HASH;
                    res_first.data_byte   = r_in_data;
                    res_first.byte_index  = n_field_cnt;
                    if (r_in_data != 8'd0) begin
                        n_hash_zero = 1'b0;
                    end
                    n_field_cnt = n_field_cnt + 64'd1;
                    if (n_field_cnt >= tiop_pkg::HASH_BYTES) begin
                        n_field_cnt = '0;
                        n_phase     = tiop_pkg::PH_INDEX;
                    end
                end
                tiop_pkg::PH_INDEX: begin
                    n_index     = n_index | (32'(r_in_data) << {n_field_cnt[1:0], 3'b000});
                    n_field_cnt = n_field_cnt + 64'd1;
                    if (n_field_cnt >= tiop_pkg::INDEX_BYTES) begin
                        n_field_cnt = '0;
                        n_phase     = tiop_pkg::PH_LENPFX;
                    end
                end
                tiop_pkg::PH_AMOUNT: begin
                    n_amount    = n_amount | (64'(r_in_data) << {n_field_cnt[2:0], 3'b000});
                    n_field_cnt = n_field_cnt + 64'd1;
                    if (n_field_cnt >= tiop_pkg::AMOUNT_BYTES) begin
                        n_field_cnt = '0;
                        n_phase     = tiop_pkg::PH_LENPFX;
                    end
                end
                tiop_pkg::PH_LENPFX: begin
                    if (r_in_data < tiop_pkg::LEN_PFX16) begin
                        n_length    = 64'(r_in_data);
                        n_field_cnt = '0;
                        if (n_length != '0) begin
                            n_phase = tiop_pkg::PH_SCRIPT;
                        end else if (n_kind) begin
                            n_segwit = 1'b0;
                            done     = 1'b1;
                        end else begin
                            n_phase = tiop_pkg::PH_SEQ;
                        end
                    end else begin
                        if (r_in_data == tiop_pkg::LEN_PFX16) begin
                            n_pfx_bytes = 4'd2;
                        end else if (r_in_data == tiop_pkg::LEN_PFX32) begin
                            n_pfx_bytes = 4'd4;
                        end else begin
                            n_pfx_bytes = 4'd8;
                        end
                        n_length    = '0;
                        n_field_cnt = '0;
                        n_phase     = tiop_pkg::PH_LENEXT;
                    end
                end
                tiop_pkg::PH_LENEXT: begin
                    n_length    = n_length | (64'(r_in_data) << {n_field_cnt[2:0], 3'b000});
                    n_field_cnt = n_field_cnt + 64'd1;
                    if (n_field_cnt >= 64'(n_pfx_bytes)) begin
                        n_field_cnt = '0;
                        if (n_length != '0) begin
                            n_phase = tiop_pkg::PH_SCRIPT;
                        end else if (n_kind) begin
                            n_segwit = 1'b0;
                            done     = 1'b1;
                        end else begin
                            n_phase = tiop_pkg::PH_SEQ;
                        end
                    end
                end
                tiop_pkg::PH_SCRIPT: begin
                    has_first             = 1'b1;
                    res_first.result_kind = tiop_pkg::RK_SCRIPT;
                    res_first.data_byte   = r_in_data;
                    res_first.byte_index  = n_field_cnt;
                    if (n_field_cnt == '0) begin
                        n_segwit = n_kind && (r_in_data <= tiop_pkg::SEGWIT_MAX_OP);
                    end
                    n_field_cnt = n_field_cnt + 64'd1;
                    if (n_field_cnt >= n_length) begin
                        n_field_cnt = '0;
                        if (n_kind) begin
                            done = 1'b1;
                        end else begin
                            n_phase = tiop_pkg::PH_SEQ;
                        end
                    end
                end
                tiop_pkg::PH_SEQ: begin
                    n_sequence  = n_sequence | (32'(r_in_data) << {n_field_cnt[1:0], 3'b000});
                    n_field_cnt = n_field_cnt + 64'd1;
                    if (n_field_cnt >= tiop_pkg::SEQ_BYTES) begin
                        n_field_cnt = '0;
                        done        = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (done) begin
                n_phase                   = tiop_pkg::PH_DONE;
                has_close                 = 1'b1;
                res_close.result_kind     = tiop_pkg::RK_DONE;
                res_close.script_length   = n_length;
                res_close.consumed_length = n_used;
                if (n_kind) begin
                    res_close.amount      = n_amount;
                    res_close.segwit_flag = n_segwit;
                end else begin
                    res_close.outpoint_index  = n_index;
                    res_close.sequence_number = n_sequence;
                    res_close.coinbase_flag   = n_hash_zero
                                                && (n_index == tiop_pkg::COINBASE_INDEX);
                end
            end else if (r_in_end) begin
                n_phase                   = tiop_pkg::PH_IDLE;
                has_close                 = 1'b1;
                res_close.result_kind     = tiop_pkg::RK_ERROR;
                res_close.consumed_length = n_used;
            end
        end

        res_first.record_kind = n_kind;
        res_first.last_of_run = !has_close;
        res_close.record_kind = n_kind;
        res_close.last_of_run = 1'b1;
    end

    assign slot0    = has_first ? res_first : res_close;
    assign slot1    = res_close;
    assign push_cnt = 2'(has_first) + 2'(has_close);
    assign n_count  = r_count + (tiop_pkg::QUEUE_AW + 1)'(push_cnt)
                      - (tiop_pkg::QUEUE_AW + 1)'(out_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tiop_pkg::PH_IDLE;
            r_kind      <= 1'b0;
            r_field_cnt <= '0;
            r_pfx_bytes <= '0;
            r_length    <= '0;
            r_index     <= '0;
            r_sequence  <= '0;
            r_amount    <= '0;
            r_hash_zero <= 1'b1;
            r_segwit    <= 1'b0;
            r_used      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
        end else begin
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_field_cnt <= n_field_cnt;
            r_pfx_bytes <= n_pfx_bytes;
            r_length    <= n_length;
            r_index     <= n_index;
            r_sequence  <= n_sequence;
            r_amount    <= n_amount;
            r_hash_zero <= n_hash_zero;
            r_segwit    <= n_segwit;
            r_used      <= n_used;
            r_tail      <= r_tail + tiop_pkg::QUEUE_AW'(push_cnt);
            r_count     <= n_count;
            if (out_pop) begin
                r_head <= r_head + tiop_pkg::QPTR_ONE;
            end
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_q[r_tail] <= slot0;
        end
        if (push_cnt == 2'd2) begin
            r_q[r_tail + tiop_pkg::QPTR_ONE] <= slot1;
        end
    end

    assign w_head = r_q[r_head];

    assign o_result_kind     = w_head.result_kind;
    assign o_data_byte       = w_head.data_byte;
    assign o_byte_index      = w_head.byte_index;
    assign o_record_kind     = w_head.record_kind;
    assign o_outpoint_index  = w_head.outpoint_index;
    assign o_sequence_number = w_head.sequence_number;
    assign o_amount          = w_head.amount;
    assign o_script_length   = w_head.script_length;
    assign o_consumed_length = w_head.consumed_length;
    assign o_coinbase_flag   = w_head.coinbase_flag;
    assign o_segwit_flag     = w_head.segwit_flag;
    assign o_last_of_run     = w_head.last_of_run;

endmodule

/* hdl/tiop_checker.sv */
// port-level checker for the record parser and its bind
`timescale 1ns / 1ps
`include "tx_input_output_record_parser_defines.svh"

module tiop_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_result_kind,
    input logic [7:0]         o_data_byte,
    input logic [63:0]        o_byte_index,
    input logic               o_record_kind,
    input logic [63:0]        o_consumed_length,
    input logic               o_segwit_flag,
    input logic               o_last_of_run
);

    // a stalled transaction holds
    `TIOP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_result_kind) && $stable(o_data_byte) && $stable(o_byte_index), "stalled result changed")

    // hash bytes belong to input records and stay inside the hash
    `TIOP_ASSERT_NOW(a_hash_range, o_out_valid && (o_result_kind == tiop_pkg::RK_HASH), (o_record_kind == 1'b0) && (o_byte_index < 64'd32) && (o_consumed_length == 64'd0), "bad hash byte result")

    // done and error close the run and carry no byte
    `TIOP_ASSERT_NOW(a_close_last, o_out_valid && ((o_result_kind == tiop_pkg::RK_DONE) || (o_result_kind == tiop_pkg::RK_ERROR)), o_last_of_run && (o_data_byte == 8'd0) && (o_byte_index == 64'd0), "bad closing result")

    // segwit only reported on a finished output record
    `TIOP_ASSERT_NOW(a_segwit_out, o_out_valid && o_segwit_flag, o_record_kind && (o_result_kind == tiop_pkg::RK_DONE), "segwit flag outside output done")

endmodule

bind tx_input_output_record_parser tiop_checker u_tiop_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_result_kind     (o_result_kind),
    .o_data_byte       (o_data_byte),
    .o_byte_index      (o_byte_index),
    .o_record_kind     (o_record_kind),
    .o_consumed_length (o_consumed_length),
    .o_segwit_flag     (o_segwit_flag),
    .o_last_of_run     (o_last_of_run)
);

/* tb/tiop_tb_pkg.sv */
// scoreboard and byte-level parser predictor for the record parser testbench
`timescale 1ns / 1ps

package tiop_tb_pkg;

    class parser_scoreboard;
        logic [3:0]        phase;
        logic              kind;
        logic [63:0]       fcnt;
        logic [3:0]        pfx_bytes;
        logic [63:0]       len_acc;
        logic [31:0]       idx_acc;
        logic [31:0]       seq_acc;
        logic [63:0]       amt_acc;
        logic              hash_zero;
        logic              segwit;
        logic [63:0]       used;
        tiop_pkg::t_result pending_results[$];
        int                errors;

        function new();
            phase = tiop_pkg::PH_IDLE;
            kind = 1'b0;
            errors = 0;
            clear_record();
        endfunction

        function void clear_record();
            fcnt = '0;
            pfx_bytes = '0;
            len_acc = '0;
            idx_acc = '0;
            seq_acc = '0;
            amt_acc = '0;
            hash_zero = 1'b1;
            segwit = 1'b0;
            used = '0;
        endfunction

        function tiop_pkg::t_result blank(input logic [1:0] rk);
            tiop_pkg::t_result r;
            r = '0;
            r.result_kind = rk;
            r.record_kind = kind;
            return r;
        endfunction

        // length decoded: go to the script, skip it when empty
        function bit length_known();
            fcnt = '0;
            if (len_acc != 0) begin
                phase = tiop_pkg::PH_SCRIPT;
                return 1'b0;
            end
            if (kind) begin
                segwit = 1'b0;
                return 1'b1;
            end
            phase = tiop_pkg::PH_SEQ;
            return 1'b0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // accepted input transaction: advance the parser and queue its results
        function void note_byte(input logic [7:0] b, input logic start, input logic act,
                                input logic pend);
            tiop_pkg::t_result r;
            tiop_pkg::t_result burst[$];
            bit                done;
            done = 1'b0;
            if (start) begin
                clear_record();
                kind = act;
                phase = act ? tiop_pkg::PH_AMOUNT : tiop_pkg::PH_HASH;
            end else if (phase == tiop_pkg::PH_IDLE || phase >= tiop_pkg::PH_DONE) begin
                return;
            end
            if (used != '1)
                used++;
            case (phase)
                tiop_pkg::PH_HASH: begin
                    r = blank(tiop_pkg::RK_HASH);
                    r.data_byte = b;
                    r.byte_index = fcnt;
                    burst.push_back(r);
                    if (b != 0)
                        hash_zero = 1'b0;
                    fcnt++;
                    if (fcnt >= tiop_pkg::HASH_BYTES) begin
                        fcnt = '0;
                        phase = tiop_pkg::PH_INDEX;
                    end
                end
                tiop_pkg::PH_INDEX: begin
                    idx_acc |= 32'(b) << {fcnt[1:0], 3'b000};
                    fcnt++;
                    if (fcnt >= tiop_pkg::INDEX_BYTES) begin
                        fcnt = '0;
                        phase = tiop_pkg::PH_LENPFX;
                    end
                end
                tiop_pkg::PH_AMOUNT: begin
                    amt_acc |= 64'(b) << {fcnt[2:0], 3'b000};
                    fcnt++;
                    if (fcnt >= tiop_pkg::AMOUNT_BYTES) begin
                        fcnt = '0;
                        phase = tiop_pkg::PH_LENPFX;
                    end
                end
                tiop_pkg::PH_LENPFX: begin
                    if (b < tiop_pkg::LEN_PFX16) begin
                        len_acc = 64'(b);
                        done = length_known();
                    end else begin
                        pfx_bytes = (b == tiop_pkg::LEN_PFX16) ? 4'd2
                                  : (b == tiop_pkg::LEN_PFX32) ? 4'd4 : 4'd8;
                        len_acc = '0;
                        fcnt = '0;
                        phase = tiop_pkg::PH_LENEXT;
                    end
                end
                tiop_pkg::PH_LENEXT: begin
                    len_acc |= 64'(b) << {fcnt[2:0], 3'b000};
                    fcnt++;
                    if (fcnt >= 64'(pfx_bytes))
                        done = length_known();
                end
                tiop_pkg::PH_SCRIPT: begin
                    r = blank(tiop_pkg::RK_SCRIPT);
                    r.data_byte = b;
                    r.byte_index = fcnt;
                    burst.push_back(r);
                    if (fcnt == 0)
                        segwit = kind ? (b <= tiop_pkg::SEGWIT_MAX_OP) : 1'b0;
                    fcnt++;
                    if (fcnt >= len_acc) begin
                        fcnt = '0;
                        if (kind)
                            done = 1'b1;
                        else
                            phase = tiop_pkg::PH_SEQ;
                    end
                end
                tiop_pkg::PH_SEQ: begin
                    seq_acc |= 32'(b) << {fcnt[1:0], 3'b000};
                    fcnt++;
                    if (fcnt >= tiop_pkg::SEQ_BYTES) begin
                        fcnt = '0;
                        done = 1'b1;
                    end
                end
                default: ;
            endcase
            if (done) begin
                phase = tiop_pkg::PH_DONE;
                r = blank(tiop_pkg::RK_DONE);
                if (kind) begin
                    r.amount = amt_acc;
                    r.segwit_flag = segwit;
                end else begin
                    r.outpoint_index = idx_acc;
                    r.sequence_number = seq_acc;
                    r.coinbase_flag = hash_zero && (idx_acc == tiop_pkg::COINBASE_INDEX);
                end
                r.script_length = len_acc;
                r.consumed_length = used;
                burst.push_back(r);
            end else if (pend) begin
                phase = tiop_pkg::PH_IDLE;
                r = blank(tiop_pkg::RK_ERROR);
                r.consumed_length = used;
                burst.push_back(r);
            end
            if (burst.size() > 0)
                burst[burst.size() - 1].last_of_run = 1'b1;
            foreach (burst[i])
                pending_results.push_back(burst[i]);
        endfunction

        task report(input string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // accepted output transaction against the oldest expected result
        task check_result(input tiop_pkg::t_result got);
            tiop_pkg::t_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result of kind %0d", got.result_kind));
                return;
            end
            want = pending_results.pop_front();
            cmp_field("result_kind", got.result_kind, want.result_kind);
            cmp_field("data_byte", got.data_byte, want.data_byte);
            cmp_field("byte_index", got.byte_index, want.byte_index);
            cmp_field("record_kind", got.record_kind, want.record_kind);
            cmp_field("outpoint_index", got.outpoint_index, want.outpoint_index);
            cmp_field("sequence_number", got.sequence_number, want.sequence_number);
            cmp_field("amount", 64'(got.amount), 64'(want.amount));
            cmp_field("script_length", got.script_length, want.script_length);
            cmp_field("consumed_length", got.consumed_length, want.consumed_length);
            cmp_field("coinbase_flag", got.coinbase_flag, want.coinbase_flag);
            cmp_field("segwit_flag", got.segwit_flag, want.segwit_flag);
            cmp_field("last_of_run", got.last_of_run, want.last_of_run);
        endtask

        task close_out();
            foreach (pending_results[i])
                report($sformatf("result of kind %0d never arrived",
                                 pending_results[i].result_kind));
            pending_results.delete();
        endtask
    endclass

endpackage

/* tb/tb_top.sv */
// top-level testbench of the transaction input/output record parser
`timescale 1ns / 1ps

module tb_top;

    localparam logic [7:0] LEN_PFX64   = 8'hFF;
    localparam int         HASH_RANDOM  = 0;
    localparam int         HASH_ZERO    = 1;
    localparam int         HASH_ONE_SET = 2;
    localparam int         LEN_FORM_1   = 0;
    localparam int         LEN_FORM_3   = 1;
    localparam int         LEN_FORM_5   = 2;
    localparam int         LEN_FORM_9   = 3;
    localparam int         SCRIPT_CAP   = 64;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         STALL_LIMIT  = 4000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [7:0]         i_data_in = '0;
    logic               i_start_req = 1'b0;
    logic               i_action = 1'b0;
    logic               i_payload_end = 1'b0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [1:0]         o_result_kind;
    logic [7:0]         o_data_byte;
    logic [63:0]        o_byte_index;
    logic               o_record_kind;
    logic [31:0]        o_outpoint_index;
    logic [31:0]        o_sequence_number;
    logic signed [63:0] o_amount;
    logic [63:0]        o_script_length;
    logic [63:0]        o_consumed_length;
    logic               o_coinbase_flag;
    logic               o_segwit_flag;
    logic               o_last_of_run;

    tiop_pkg::t_result             out_word;
    tiop_tb_pkg::parser_scoreboard sb = new();
    logic [7:0]                    rec[$];
    bit                            rec_whole;
    int                            record_bytes = 0;
    int                            src_idle_pct = 0;
    int                            sink_idle_pct = 0;
    logic                          hold_go = 1'b0;
    logic                          hold_taken = 1'b0;
    int                            hold_left = 0;
    int                            idle_cycles = 0;

    tx_input_output_record_parser u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_in         (i_data_in),
        .i_start_req       (i_start_req),
        .i_action          (i_action),
        .i_payload_end     (i_payload_end),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_result_kind     (o_result_kind),
        .o_data_byte       (o_data_byte),
        .o_byte_index      (o_byte_index),
        .o_record_kind     (o_record_kind),
        .o_outpoint_index  (o_outpoint_index),
        .o_sequence_number (o_sequence_number),
        .o_amount          (o_amount),
        .o_script_length   (o_script_length),
        .o_consumed_length (o_consumed_length),
        .o_coinbase_flag   (o_coinbase_flag),
        .o_segwit_flag     (o_segwit_flag),
        .o_last_of_run     (o_last_of_run)
    );

    assign out_word = {o_result_kind, o_data_byte, o_byte_index, o_record_kind,
                       o_outpoint_index, o_sequence_number, o_amount, o_script_length,
                       o_consumed_length, o_coinbase_flag, o_segwit_flag, o_last_of_run};

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_byte(i_data_in, i_start_req, i_action, i_payload_end);
            if (o_out_valid && !i_out_stall)
                sb.check_result(out_word);
        end
    end

    // result side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic st, input logic act,
                             input logic pend);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_in <= b;
        i_start_req <= st;
        i_action <= act;
        i_payload_end <= pend;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic send_junk();
        send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)), ($urandom_range(3) == 0));
    endtask

    task automatic send_rec(input logic kind, input int count, input logic end_last);
        for (int i = 0; i < count; i++)
            send_byte(rec[i], (i == 0), (i == 0) ? kind : 1'($urandom_range(1)),
                      end_last && (i == count - 1));
        record_bytes += count;
    endtask

    task automatic build_rec(input logic kind, input int hash_mode, input logic [31:0] idx,
                             input logic [63:0] amt, input logic [63:0] slen, input int form,
                             input logic [7:0] first_op, input logic [31:0] seq);
        int n;
        rec.delete();
        if (!kind) begin
            for (int i = 0; i < 32; i++)
                rec.push_back(hash_mode == HASH_RANDOM ? 8'($urandom) : 8'h00);
            if (hash_mode == HASH_ONE_SET)
                rec[$urandom_range(31)] = 8'($urandom_range(255, 1));
            for (int i = 0; i < 4; i++)
                rec.push_back(idx[8*i +: 8]);
        end else begin
            for (int i = 0; i < 8; i++)
                rec.push_back(amt[8*i +: 8]);
        end
        case (form)
            LEN_FORM_1: rec.push_back(slen[7:0]);
            LEN_FORM_3: begin
                rec.push_back(tiop_pkg::LEN_PFX16);
                for (int i = 0; i < 2; i++)
                    rec.push_back(slen[8*i +: 8]);
            end
            LEN_FORM_5: begin
                rec.push_back(tiop_pkg::LEN_PFX32);
                for (int i = 0; i < 4; i++)
                    rec.push_back(slen[8*i +: 8]);
            end
            default: begin
                rec.push_back(LEN_PFX64);
                for (int i = 0; i < 8; i++)
                    rec.push_back(slen[8*i +: 8]);
            end
        endcase
        rec_whole = (slen <= 64'(SCRIPT_CAP));
        n = rec_whole ? int'(slen) : SCRIPT_CAP;
        for (int i = 0; i < n; i++)
            rec.push_back(i == 0 ? first_op : 8'($urandom));
        if (!kind && rec_whole) begin
            for (int i = 0; i < 4; i++)
                rec.push_back(seq[8*i +: 8]);
        end
    endtask

    task automatic pick_length(output logic [63:0] slen, output int form);
        int sel;
        sel = $urandom_range(99);
        form = LEN_FORM_1;
        if (sel < 15) begin
            slen = '0;
        end else if (sel < 60) begin
            slen = 64'($urandom_range(12, 1));
        end else if (sel < 72) begin
            slen = 64'($urandom_range(60, 13));
        end else if (sel < 86) begin
            slen = 64'($urandom_range(40));
            form = $urandom_range(LEN_FORM_9, LEN_FORM_3);
        end else if (sel < 92) begin
            slen = {$urandom, $urandom};
            form = LEN_FORM_9;
        end else if (sel < 96) begin
            slen = 64'($urandom);
            form = LEN_FORM_5;
        end else begin
            slen = 64'($urandom_range(16'hFFFF, 8'hFD));
            form = LEN_FORM_3;
        end
    endtask

    task automatic random_record();
        logic        kind;
        logic [63:0] slen;
        logic [31:0] idx;
        logic [7:0]  first_op;
        int          form;
        int          hm;
        int          sel;
        kind = 1'($urandom_range(1));
        pick_length(slen, form);
        sel = $urandom_range(99);
        hm = (sel < 60) ? HASH_RANDOM : (sel < 85) ? HASH_ZERO : HASH_ONE_SET;
        idx = ($urandom_range(3) == 0) ? tiop_pkg::COINBASE_INDEX : 32'($urandom);
        first_op = $urandom_range(1)
                   ? 8'($urandom_range(tiop_pkg::SEGWIT_MAX_OP + 1))
                   : 8'($urandom);
        build_rec(kind, hm, idx, {$urandom, $urandom}, slen, form, first_op, 32'($urandom));
        sel = $urandom_range(99);
        if (!rec_whole || sel < 15) begin
            send_rec(kind, $urandom_range(rec.size(), 1), 1'b1);
        end else if (sel < 25) begin
            // abandoned: the next start byte restarts the parser
            send_rec(kind, $urandom_range(rec.size() - 1, 1), 1'b0);
        end else begin
            send_rec(kind, rec.size(), 1'($urandom_range(1)));
            repeat ($urandom_range(2))
                send_junk();
        end
    endtask

    task automatic random_phase(input int target);
        int first;
        first = record_bytes;
        while (record_bytes - first < target) begin
            if ($urandom_range(99) < 5) begin
                repeat ($urandom_range(4, 1))
                    send_junk();
            end else begin
                random_record();
            end
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    task automatic directed_records();
        // coinbase input with empty script
        build_rec(1'b0, HASH_ZERO, tiop_pkg::COINBASE_INDEX, '0, '0, LEN_FORM_1, 8'h00,
                  32'hFFFF_FFFF);
        send_rec(1'b0, rec.size(), 1'b1);
        // zero hash, index not all ones
        build_rec(1'b0, HASH_ZERO, 32'hFFFF_FFFE, '0, 64'd1, LEN_FORM_1, 8'h00, '0);
        send_rec(1'b0, rec.size(), 1'b0);
        // one hash byte set, 3-byte length, trailing bytes ignored
        build_rec(1'b0, HASH_ONE_SET, tiop_pkg::COINBASE_INDEX, '0, 64'd3, LEN_FORM_3, 8'hFF,
                  '0);
        send_rec(1'b0, rec.size(), 1'b0);
        send_junk();
        send_junk();
        // empty output script is legacy
        build_rec(1'b1, HASH_RANDOM, '0, 64'h8000_0000_0000_0000, '0, LEN_FORM_1, 8'h00, '0);
        send_rec(1'b1, rec.size(), 1'b1);
        build_rec(1'b1, HASH_RANDOM, '0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, LEN_FORM_1, 8'h00,
                  '0);
        send_rec(1'b1, rec.size(), 1'b1);
        build_rec(1'b1, HASH_RANDOM, '0, {$urandom, $urandom}, 64'd2, LEN_FORM_5,
                  tiop_pkg::SEGWIT_MAX_OP, '0);
        send_rec(1'b1, rec.size(), 1'b0);
        build_rec(1'b1, HASH_RANDOM, '0, {$urandom, $urandom}, 64'd3, LEN_FORM_9,
                  tiop_pkg::SEGWIT_MAX_OP + 8'd1, '0);
        send_rec(1'b1, rec.size(), 1'b0);
        // all-ones length, payload ends inside the script
        build_rec(1'b1, HASH_RANDOM, '0, '0, '1, LEN_FORM_9, 8'h00, '0);
        send_rec(1'b1, rec.size(), 1'b1);
        // payload ends inside the length field
        build_rec(1'b1, HASH_RANDOM, '0, '1, 64'd5, LEN_FORM_3, 8'h00, '0);
        send_rec(1'b1, 10, 1'b1);
        // restart in the middle of an output, then end on the last script byte
        build_rec(1'b1, HASH_RANDOM, '0, '1, 64'd1, LEN_FORM_1, 8'h00, '0);
        send_rec(1'b1, 4, 1'b0);
        build_rec(1'b0, HASH_RANDOM, '0, '0, 64'd2, LEN_FORM_1, 8'h07, '0);
        send_rec(1'b0, 39, 1'b1);
        // payload ends on the start byte
        send_byte(8'h00, 1'b1, 1'b1, 1'b1);
        send_byte(8'hA5, 1'b1, 1'b0, 1'b1);
        repeat (3)
            send_junk();
    endtask

    initial begin
        repeat (5)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_records();
        drain();

        src_idle_pct = 9;
        sink_idle_pct = 80;
        random_phase(230);
        drain();

        src_idle_pct = 80;
        sink_idle_pct = 9;
        random_phase(230);
        drain();

        src_idle_pct = 0;
        sink_idle_pct = 0;
        hold_go <= 1'b1;
        repeat (2) begin
            build_rec(1'b0, HASH_RANDOM, 32'($urandom), '0, 64'd20, LEN_FORM_1, 8'($urandom),
                      32'($urandom));
            send_rec(1'b0, rec.size(), 1'b0);
        end
        drain();
        random_phase(230);
        drain();

        repeat (32)
            @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
